// File: rtl/core/snfd_pkg.sv
// snfd_pkg: opcodes, reset values and shared types of the spi nor flash device
// used by every module in rtl/core; has no dependencies of its own
`timescale 1ns / 1ps
`default_nettype none

package snfd_pkg;

   // default sizes, handed to the top level parameters
   localparam int DefaultFlashAddrBits = 16;
   localparam int DefaultQueueDepth    = 16;

   // fixed widths
   localparam int AddrW     = 24;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 64;
   localparam int MaxPush   = 12;
   localparam int PushIdxW  = 4;
   localparam int PushCntW  = 4;

   // register indexes of the configuration port
   localparam logic [CsrIndexW-1:0] CsrJedecId  = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrDeviceId = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrUniqueId = 2'd2;

   // register reset values
   localparam logic [23:0] JedecIdReset  = 24'hEF4015;
   localparam logic [7:0]  DeviceIdReset = 8'h14;
   localparam logic [63:0] UniqueIdReset = 64'h0123456789ABCDEF;

   localparam logic [7:0] ByteIdle   = 8'hFF;
   localparam logic [7:0] ByteFiller = 8'h00;

   // command opcodes, also used as mode codes
   localparam logic [7:0] ModeCommand     = 8'h00;
   localparam logic [7:0] OpRead          = 8'h03;
   localparam logic [7:0] OpProgram       = 8'h02;
   localparam logic [7:0] OpReadStatus1   = 8'h05;
   localparam logic [7:0] OpReadStatus2   = 8'h35;
   localparam logic [7:0] OpReadStatus3   = 8'h15;
   localparam logic [7:0] OpErase4k       = 8'h20;
   localparam logic [7:0] OpErase32k      = 8'h52;
   localparam logic [7:0] OpErase64k      = 8'hD8;
   localparam logic [7:0] OpUniqueId      = 8'h4B;
   localparam logic [7:0] OpMfrDeviceId   = 8'h90;
   localparam logic [7:0] OpJedecId       = 8'h9F;
   localparam logic [7:0] OpWake          = 8'hAB;
   localparam logic [7:0] OpWriteDisable  = 8'h04;
   localparam logic [7:0] OpWriteEnable   = 8'h06;
   localparam logic [7:0] OpSleep         = 8'hB9;

   // one exchange's worth of reply queue control
   typedef struct packed {
      logic                         flush;
      logic                         pop;
      logic [PushCntW-1:0]          count;
      logic [MaxPush-1:0][7:0]      data;
   } reply_push_type;

endpackage

`default_nettype wire

// File: rtl/core/snfd_reply_queue.sv
// snfd_reply_queue: reply byte fifo, one pop and up to MaxPush pushes per word
// depends on snfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module snfd_reply_queue #(
   parameter int DEPTH = snfd_pkg::DefaultQueueDepth
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire snfd_pkg::reply_push_type   push,
   output logic [7:0]                      head,
   output logic                            nonempty
);
   import snfd_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [7:0]    q_ff [DEPTH];
   logic [7:0]    q_in [DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          pop_en;
   logic [CW-1:0] base;
   logic [SW-1:0] total;

   assign pop_en = push.pop && (count_ff != '0);
   assign base   = count_ff - CW'(pop_en);
   assign total  = SW'(base) + SW'(push.count);

   always_comb begin
      if (push.flush) begin
         count_in = '0;
      end else if (total > SW'(DEPTH)) begin
         count_in = CW'(DEPTH);
      end else begin
         count_in = total[CW-1:0];
      end
   end

   for (genvar j = 0; j < DEPTH; j++) begin : g_entry
      localparam int Next = (j < DEPTH - 1) ? j + 1 : j;
      logic [CW-1:0] offset;

      assign offset = CW'(j) - base;

      always_comb begin
         if (CW'(j) < base) begin
            q_in[j] = pop_en ? q_ff[Next] : q_ff[j];
         end else if (offset < CW'(push.count)) begin
            q_in[j] = push.data[offset[PushIdxW-1:0]];
         end else begin
            q_in[j] = q_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign head     = q_ff[0];
   assign nonempty = (count_ff != '0);

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("reply queue count beyond depth");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      push.flush |=> count_ff == '0)
      else $error("reply queue not empty after flush");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      push.pop && !push.flush && count_ff != '0 && push.count == '0
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("reply queue pop miscounted");

endmodule

`default_nettype wire

// File: rtl/core/snfd_flash_mem.sv
// snfd_flash_mem: byte-wide flash array with registered read and erase sweep
// after reset; depends on snfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module snfd_flash_mem #(
   parameter int ADDR_BITS = snfd_pkg::DefaultFlashAddrBits
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [7:0]           wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]                rd_data,
   output logic                      busy
);
   import snfd_pkg::*;

   logic [7:0]           mem [2**ADDR_BITS];
   logic [7:0]           rd_data_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [ADDR_BITS-1:0] clr_addr_in;
   logic                 clearing_ff;
   logic                 clearing_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // erase sweep owns the write port until it finishes
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= ByteIdle;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

`default_nettype wire

// File: rtl/core/spi_nor_flash_device_unit.sv
// spi_nor_flash_device_unit: chip side of an spi nor flash, one byte exchange per word
// depends on snfd_pkg, snfd_flash_mem and snfd_reply_queue
//
// Usage:
//   req channel: req_operation 0 exchanges req_mosi_byte for one reply byte,
//   1 is a chip deselect (reply 0xFF) that empties both queues and returns to
//   command mode. rsp channel: one rsp_miso_byte word for every req word.
//   csr port: csr_index 0 jedec id, 1 device id, 2 unique id; write only while
//   idle.
// Timing:
//   a reply word is valid the cycle after its request is taken; one word per
//   cycle is accepted while req_stall is low, set by the single result register
//   and the registered array read, which is fetched ahead at the next byte address.
// Reset:
//   the array is erased to 0xFF by a sweep over all 2**FLASH_ADDR_BITS bytes, one
//   byte a cycle, while req_stall is held high; csr writes are taken as ever.
// Stall:
//   while rsp_stall holds a waiting word, req_stall is raised; a word accepted
//   in the cycle the result register drains goes straight into it.
`timescale 1ns / 1ps
`default_nettype none

module spi_nor_flash_device_unit #(
   parameter int FLASH_ADDR_BITS = snfd_pkg::DefaultFlashAddrBits,
   parameter int QUEUE_DEPTH     = snfd_pkg::DefaultQueueDepth
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_operation,
   input  wire logic [7:0]                       req_mosi_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_miso_byte,
   input  wire logic                             csr_write_enable,
   input  wire logic [snfd_pkg::CsrIndexW-1:0]   csr_index,
   input  wire logic [snfd_pkg::CsrDataW-1:0]    csr_write_data
);
   import snfd_pkg::*;

   // configuration
   logic [23:0] jedec_id_ff;
   logic [7:0]  device_id_ff;
   logic [63:0] unique_id_ff;

   // control state
   logic [7:0]       mode_ff, mode_in;
   logic [AddrW-1:0] byte_address_ff, byte_address_in;
   logic             asleep_ff, asleep_in;
   logic             wel_ff, wel_in;
   logic [1:0]       cmd_count_ff, cmd_count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [7:0] cmd_head_ff, cmd_head_in;
   logic [7:0] cmd_addr1_ff, cmd_addr1_in;
   logic [7:0] cmd_addr2_ff, cmd_addr2_in;
   logic [7:0] rsp_miso_byte_ff;
   logic [7:0] rx;

   logic                       accept;
   logic                       in_range;
   logic                       mem_wr_en;
   logic [7:0]                 mem_rd_data;
   logic                       mem_busy;
   logic [2:0]                 cnt_after;
   logic [7:0]                 head;
   logic [7:0]                 reply_head;
   logic                       reply_nonempty;
   reply_push_type             rp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = mem_busy || (rsp_valid_ff && rsp_stall);
   assign in_range  = (byte_address_ff >> FLASH_ADDR_BITS) == '0;
   assign cnt_after = {1'b0, cmd_count_ff} + 3'd1;
   assign head      = (cmd_count_ff == 2'd0) ? req_mosi_byte : cmd_head_ff;

   always_comb begin
      mode_in         = mode_ff;
      byte_address_in = byte_address_ff;
      asleep_in       = asleep_ff;
      wel_in          = wel_ff;
      cmd_count_in    = cmd_count_ff;
      cmd_head_in     = cmd_head_ff;
      cmd_addr1_in    = cmd_addr1_ff;
      cmd_addr2_in    = cmd_addr2_ff;
      mem_wr_en       = 1'b0;
      rx              = ByteIdle;
      rp              = '0;

      if (accept && req_operation) begin
         rp.flush     = 1'b1;
         cmd_count_in = 2'd0;
         mode_in      = ModeCommand;
      end else if (accept) begin
         case (mode_ff)
            OpRead: begin
               rx              = in_range ? mem_rd_data : ByteIdle;
               byte_address_in = byte_address_ff + 1'b1;
            end
            OpProgram: begin
               mem_wr_en       = in_range;
               byte_address_in = {byte_address_ff[AddrW-1:8], byte_address_ff[7:0] + 8'd1};
            end
            OpReadStatus1: begin
               rx = {6'd0, wel_ff, 1'b0};
            end
            OpReadStatus2, OpReadStatus3: begin
               rx = ByteFiller;
            end
            OpErase4k, OpErase32k, OpErase64k: begin
               rx = ByteIdle;
            end
            default: begin
               rp.pop = 1'b1;
               rx     = reply_nonempty ? reply_head : ByteIdle;
               if (asleep_ff && head != OpWake) begin
                  // lockout: keep the head so the device stays deaf until deselect
                  rx = ByteIdle;
                  if (cmd_count_ff == 2'd0) begin
                     cmd_head_in  = req_mosi_byte;
                     cmd_count_in = 2'd1;
                  end
               end else begin
                  cmd_count_in = 2'd0;
                  case (head)
                     OpRead, OpProgram, OpErase4k, OpErase32k, OpErase64k,
                     OpMfrDeviceId: begin
                        if (cnt_after == 3'd4) begin
                           if (head == OpMfrDeviceId) begin
                              rp.count   = PushCntW'(2);
                              rp.data[0] = jedec_id_ff[23:16];
                              rp.data[1] = device_id_ff;
                           end else begin
                              mode_in         = head;
                              byte_address_in = {cmd_addr1_ff, cmd_addr2_ff, req_mosi_byte};
                           end
                        end else begin
                           // still gathering address bytes
                           cmd_count_in = cnt_after[1:0];
                           case (cmd_count_ff)
                              2'd0:    cmd_head_in  = req_mosi_byte;
                              2'd1:    cmd_addr1_in = req_mosi_byte;
                              default: cmd_addr2_in = req_mosi_byte;
                           endcase
                        end
                     end
                     OpReadStatus1, OpReadStatus2, OpReadStatus3: begin
                        mode_in = head;
                     end
                     OpUniqueId: begin
                        rp.count = PushCntW'(12);
                        for (int i = 0; i < 8; i++) begin
                           rp.data[4 + i] = unique_id_ff[63 - 8 * i -: 8];
                        end
                     end
                     OpJedecId: begin
                        rp.count   = PushCntW'(3);
                        rp.data[0] = jedec_id_ff[23:16];
                        rp.data[1] = jedec_id_ff[15:8];
                        rp.data[2] = jedec_id_ff[7:0];
                     end
                     OpWake: begin
                        asleep_in  = 1'b0;
                        rp.count   = PushCntW'(4);
                        rp.data[3] = device_id_ff;
                     end
                     OpWriteDisable: wel_in    = 1'b0;
                     OpWriteEnable:  wel_in    = 1'b1;
                     OpSleep:        asleep_in = 1'b1;
                     default: begin
                        // unknown command clears the command queue
                        cmd_count_in = 2'd0;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= ModeCommand;
         byte_address_ff <= '0;
         asleep_ff       <= 1'b0;
         wel_ff          <= 1'b0;
         cmd_count_ff    <= 2'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         byte_address_ff <= byte_address_in;
         asleep_ff       <= asleep_in;
         wel_ff          <= wel_in;
         cmd_count_ff    <= cmd_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_head_ff  <= cmd_head_in;
      cmd_addr1_ff <= cmd_addr1_in;
      cmd_addr2_ff <= cmd_addr2_in;
      if (accept) begin
         rsp_miso_byte_ff <= rx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jedec_id_ff  <= JedecIdReset;
         device_id_ff <= DeviceIdReset;
         unique_id_ff <= UniqueIdReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrJedecId:  jedec_id_ff  <= csr_write_data[23:0];
            CsrDeviceId: device_id_ff <= csr_write_data[7:0];
            CsrUniqueId: unique_id_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // read port fetches the next word's address so data is ready on accept
   snfd_flash_mem #(
      .ADDR_BITS (FLASH_ADDR_BITS)
   ) u_flash_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (byte_address_ff[FLASH_ADDR_BITS-1:0]),
      .wr_data (req_mosi_byte),
      .rd_addr (byte_address_in[FLASH_ADDR_BITS-1:0]),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

   snfd_reply_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_reply_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rp),
      .head     (reply_head),
      .nonempty (reply_nonempty)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_miso_byte = rsp_miso_byte_ff;

   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> req_stall)
      else $error("word taken during erase sweep");

   a_read_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !req_operation && mode_ff == OpRead
      |=> byte_address_ff == AddrW'($past(byte_address_ff) + 24'd1))
      else $error("read address did not advance");

   a_deselect_mode: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation |=> mode_ff == ModeCommand && cmd_count_ff == 2'd0)
      else $error("deselect did not return to command mode");

endmodule

`default_nettype wire
